// ===== rtl/command_line_tokenizer_unit_defines.svh =====
// Assertion macros for the tokenizer RTL, used by the decoder.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CLT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed one cycle later");

`else

`define CLT_ASSERT_SAME(label, ante, cons)
`define CLT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/clt_pkg.sv =====
`timescale 1ns / 1ps

package clt_pkg;

    // Characters with a special meaning to the tokenizer.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_NUL       = 8'h00;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_DANGLING  = 2'd1,
        ERR_SHORT_HEX = 2'd2,
        ERR_BAD_HEX   = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       ends_token;
        logic       ends_command;
        logic [1:0] error;
    } tok_result_t;

    // Bit 4 set means the character is not a hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

// ===== rtl/clt_if.sv =====
`timescale 1ns / 1ps

interface clt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface clt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       ends_token;
    logic       ends_command;
    logic [1:0] error;

    modport source (output valid, output out_byte, output has_byte, output ends_token,
                    output ends_command, output error, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input ends_token,
                    input ends_command, input error, output ready);
endinterface

// ===== rtl/command_line_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// Channel   Role   Payload                                              Width
// cmd_in    sink   in_byte, last                                        8+1
// tok_out   source out_byte, has_byte, ends_token, ends_command, error  8+1+1+1+2
//
// One input byte gives exactly one result transaction. A byte is decoded while it sits in
// the input register and its result is loaded into the result register, which drives
// tok_out valid, once that register has space. One byte per cycle is sustained while
// tok_out does not stall.
// rst_n is asynchronous and active low; it clears the valid flags and the quote,
// escape and skip state. When tok_out stalls, the result register holds its transaction
// and the input register fills; cmd_in ready then drops until the stall clears.

module command_line_tokenizer_unit (
    input  logic      clk,
    input  logic      rst_n,
    clt_in_if.sink    cmd_in,
    clt_out_if.source tok_out
);
    import clt_pkg::*;

    logic        item_valid;
    byte_item_t  item;
    logic        out_space;
    logic        fire;
    tok_result_t result;

    // A byte moves from the input register to the result register when both agree.
    // The decoder state advances in the same cycle, so each byte is decoded once.
    assign fire = item_valid && out_space;

    clt_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (cmd_in),
        .take  (fire),
        .valid (item_valid),
        .item  (item)
    );

    // The escape, quote and skip state machine decides each byte combinationally.
    clt_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    // The result register decouples the consumer so a stall does not lose a result.
    clt_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (item_valid),
        .result (result),
        .space  (out_space),
        .out_ch (tok_out)
    );
endmodule

// ===== rtl/clt_in_stage.sv =====
`timescale 1ns / 1ps

module clt_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    clt_in_if.sink              in_ch,
    input  logic                take,
    output logic                valid,
    output clt_pkg::byte_item_t item
);
    import clt_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    // Accept a new byte whenever the register is empty or is drained this cycle.
    assign in_ch.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ch.ready)
        begin
            valid_next = in_ch.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= '{in_byte: in_ch.in_byte, last: in_ch.last};
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;
endmodule

// ===== rtl/clt_decoder.sv =====
`timescale 1ns / 1ps
`include "command_line_tokenizer_unit_defines.svh"

module clt_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  clt_pkg::byte_item_t  item,
    output clt_pkg::tok_result_t result
);
    import clt_pkg::*;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ESC    = 2'd1,
        PH_HEX1   = 2'd2,
        PH_HEX2   = 2'd3
    } phase_t;

    logic       quoting_reg,    quoting_next;
    logic       token_open_reg, token_open_next;
    phase_t     phase_reg,      phase_next;
    logic [3:0] hex_high_reg,   hex_high_next;
    logic       skipping_reg,   skipping_next;

    logic [7:0] c;
    logic [4:0] hv;
    logic [7:0] obyte;
    logic       has;
    logic       etok;
    err_code_t  err;

    assign c  = item.in_byte;
    assign hv = hex_value(c);

    always_comb
    begin
        quoting_next    = quoting_reg;
        token_open_next = token_open_reg;
        phase_next      = phase_reg;
        hex_high_next   = hex_high_reg;
        skipping_next   = skipping_reg;
        obyte           = CH_NUL;
        has             = 1'b0;
        etok            = 1'b0;
        err             = ERR_NONE;

        if (!skipping_reg)
        begin
            case (phase_reg)
                PH_ESC:
                begin
                    phase_next = PH_NORMAL;
                    if (c == CH_X)
                    begin
                        if (item.last)
                            err = ERR_SHORT_HEX;
                        else
                            phase_next = PH_HEX1;
                    end
                    else
                    begin
                        case (c)
                            CH_N:    obyte = CH_LF;
                            CH_R:    obyte = CH_CR;
                            CH_B:    obyte = CH_BS;
                            CH_T:    obyte = CH_TAB;
                            CH_ZERO: obyte = CH_NUL;
                            default: obyte = c;
                        endcase
                        has             = 1'b1;
                        token_open_next = 1'b1;
                    end
                end
                PH_HEX1:
                begin
                    phase_next = PH_NORMAL;
                    if (item.last)
                        err = ERR_SHORT_HEX;
                    else if (hv[4])
                        err = ERR_BAD_HEX;
                    else
                    begin
                        hex_high_next = hv[3:0];
                        phase_next    = PH_HEX2;
                    end
                end
                PH_HEX2:
                begin
                    phase_next = PH_NORMAL;
                    if (hv[4])
                        err = ERR_BAD_HEX;
                    else
                    begin
                        obyte           = {hex_high_reg, hv[3:0]};
                        has             = 1'b1;
                        token_open_next = 1'b1;
                    end
                end
                PH_NORMAL:
                begin
                    if (c == CH_BACKSLASH)
                    begin
                        if (item.last)
                            err = ERR_DANGLING;
                        else
                            phase_next = PH_ESC;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        quoting_next = !quoting_reg;
                        if (!quoting_reg)
                            token_open_next = 1'b1;
                    end
                    else if (is_space(c))
                    begin
                        if (quoting_reg)
                        begin
                            obyte = c;
                            has   = 1'b1;
                        end
                        else if (token_open_reg)
                        begin
                            etok            = 1'b1;
                            token_open_next = 1'b0;
                        end
                    end
                    else
                    begin
                        obyte           = c;
                        has             = 1'b1;
                        token_open_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_NORMAL;
                end
            endcase
        end

        if (err != ERR_NONE)
        begin
            obyte         = CH_NUL;
            has           = 1'b0;
            etok          = 1'b0;
            skipping_next = 1'b1;
        end

        // The final byte closes any open token, unless an error has set skipping, and returns to the idle state.
        if (item.last)
        begin
            if (!skipping_next && token_open_next)
                etok = 1'b1;
            quoting_next    = 1'b0;
            token_open_next = 1'b0;
            phase_next      = PH_NORMAL;
            hex_high_next   = 4'd0;
            skipping_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoting_reg    <= 1'b0;
            token_open_reg <= 1'b0;
            phase_reg      <= PH_NORMAL;
            hex_high_reg   <= 4'd0;
            skipping_reg   <= 1'b0;
        end
        else if (fire)
        begin
            quoting_reg    <= quoting_next;
            token_open_reg <= token_open_next;
            phase_reg      <= phase_next;
            hex_high_reg   <= hex_high_next;
            skipping_reg   <= skipping_next;
        end
    end

    assign result = '{out_byte:     obyte,
                      has_byte:     has,
                      ends_token:   etok,
                      ends_command: item.last,
                      error:        err};

    `CLT_ASSERT_SAME(a_err_no_payload, fire && err != ERR_NONE, !has && !etok)
    `CLT_ASSERT_SAME(a_byte_zero_when_empty, fire && !has, obyte == CH_NUL)
    `CLT_ASSERT_SAME(a_skip_is_silent, fire && skipping_reg, err == ERR_NONE && !has && !etok)
    `CLT_ASSERT_NEXT(a_last_clears_state, fire && item.last,
                     phase_reg == PH_NORMAL && !quoting_reg && !skipping_reg && !token_open_reg)
endmodule

// ===== rtl/clt_out_stage.sv =====
`timescale 1ns / 1ps

module clt_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  clt_pkg::tok_result_t result,
    output logic                 space,
    clt_out_if.source            out_ch
);
    import clt_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    tok_result_t result_reg;

    // The register can take a result when empty or when its content leaves now.
    assign space = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && space)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.out_byte     = result_reg.out_byte;
    assign out_ch.has_byte     = result_reg.has_byte;
    assign out_ch.ends_token   = result_reg.ends_token;
    assign out_ch.ends_command = result_reg.ends_command;
    assign out_ch.error        = result_reg.error;
endmodule

// ===== dv/tokenizer_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts each token result from the accepted bytes and
// compares what comes out against the oldest prediction.
module tokenizer_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       has_byte,
    input  logic       ends_token,
    input  logic       ends_command,
    input  logic [1:0] error,
    output int         mismatches,
    output int         pending
);
    import clt_pkg::*;

    typedef enum logic [1:0] {
        ESC_IDLE    = 2'd0,
        ESC_PENDING = 2'd1,
        ESC_HEX_HI  = 2'd2,
        ESC_HEX_LO  = 2'd3
    } esc_phase_t;

    // Predicted tokenizer state.
    logic       quoting    = 1'b0;
    logic       token_open = 1'b0;
    logic       skipping   = 1'b0;
    esc_phase_t esc_phase  = ESC_IDLE;
    logic [3:0] hex_hi     = 4'h0;

    tok_result_t decoded_q[$];
    int          mismatch_cnt = 0;
    int          pending_cnt  = 0;

    assign mismatches = mismatch_cnt;
    assign pending    = pending_cnt;

    // Value of a hex digit, or -1 when the byte is not one.
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    task automatic advance_tokenizer(input logic [7:0] c, input logic fin,
                                     output tok_result_t r);
        int        nib;
        err_code_t err;
        r   = '0;
        err = ERR_NONE;
        nib = nibble_of(c);
        if (!skipping)
        begin
            case (esc_phase)
                ESC_PENDING:
                begin
                    esc_phase = ESC_IDLE;
                    if (c == CH_X)
                    begin
                        if (fin) err = ERR_SHORT_HEX;
                        else esc_phase = ESC_HEX_HI;
                    end
                    else
                    begin
                        case (c)
                            CH_N:    r.out_byte = CH_LF;
                            CH_R:    r.out_byte = CH_CR;
                            CH_B:    r.out_byte = CH_BS;
                            CH_T:    r.out_byte = CH_TAB;
                            CH_ZERO: r.out_byte = CH_NUL;
                            default: r.out_byte = c;
                        endcase
                        r.has_byte = 1'b1;
                        token_open = 1'b1;
                    end
                end
                ESC_HEX_HI:
                begin
                    esc_phase = ESC_IDLE;
                    if (fin) err = ERR_SHORT_HEX;
                    else if (nib < 0) err = ERR_BAD_HEX;
                    else
                    begin
                        hex_hi    = nib[3:0];
                        esc_phase = ESC_HEX_LO;
                    end
                end
                ESC_HEX_LO:
                begin
                    esc_phase = ESC_IDLE;
                    if (nib < 0) err = ERR_BAD_HEX;
                    else
                    begin
                        r.out_byte = {hex_hi, nib[3:0]};
                        r.has_byte = 1'b1;
                        token_open = 1'b1;
                    end
                end
                default:
                begin
                    if (c == CH_BACKSLASH)
                    begin
                        if (fin) err = ERR_DANGLING;
                        else esc_phase = ESC_PENDING;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        quoting = !quoting;
                        if (quoting) token_open = 1'b1;
                    end
                    else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)
                    begin
                        // Separators are ordinary token bytes inside quotes.
                        if (quoting)
                        begin
                            r.out_byte = c;
                            r.has_byte = 1'b1;
                        end
                        else if (token_open)
                        begin
                            r.ends_token = 1'b1;
                            token_open   = 1'b0;
                        end
                    end
                    else
                    begin
                        r.out_byte = c;
                        r.has_byte = 1'b1;
                        token_open = 1'b1;
                    end
                end
            endcase
        end

        if (err != ERR_NONE)
        begin
            r.out_byte   = 8'h00;
            r.has_byte   = 1'b0;
            r.ends_token = 1'b0;
            skipping     = 1'b1;
        end

        if (fin)
        begin
            if (!skipping && token_open) r.ends_token = 1'b1;
            quoting    = 1'b0;
            token_open = 1'b0;
            skipping   = 1'b0;
            esc_phase  = ESC_IDLE;
            hex_hi     = 4'h0;
        end
        r.ends_command = fin;
        r.error        = err;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        tok_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                advance_tokenizer(in_byte, in_last, want);
                decoded_q.insert(decoded_q.size(), want);
            end
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual byte 0x%0h err %0d",
                             $time, out_byte, error);
                    mismatch_cnt++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    compare_field("out_byte", want.out_byte, out_byte);
                    compare_field("has_byte", want.has_byte, has_byte);
                    compare_field("ends_token", want.ends_token, ends_token);
                    compare_field("ends_command", want.ends_command, ends_command);
                    compare_field("error", want.error, error);
                end
            end
            pending_cnt = decoded_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Top of the tokenizer testbench. This module only makes stimulus and gives the
// verdict; prediction and comparison live in the checker instantiated beside the block.
module testbench;
    import clt_pkg::*;

    // Each of the four idling phases sends roughly this many random bytes.
    localparam int PHASE_BYTES     = 238;
    // Length of the long receiver hold-off that forces the block to back up.
    localparam int HOLD_OFF_CYCLES = 60;
    // Cycles without any transaction on either channel before the run is abandoned.
    localparam int STALL_LIMIT     = 2000;

    logic clk;
    logic rst_n;

    clt_in_if  cmd_in ();
    clt_out_if tok_out ();

    // Idle percentages of the sender and the receiver for the current phase.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req       = 1'b0;

    int mismatches;
    int pending;

    // Bytes of the command that is about to be sent.
    logic [7:0] cmd_bytes[$];

    command_line_tokenizer_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_in),
        .tok_out (tok_out)
    );

    tokenizer_checker tok_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cmd_in.valid),
        .in_ready     (cmd_in.ready),
        .in_byte      (cmd_in.in_byte),
        .in_last      (cmd_in.last),
        .out_valid    (tok_out.valid),
        .out_ready    (tok_out.ready),
        .out_byte     (tok_out.out_byte),
        .has_byte     (tok_out.has_byte),
        .ends_token   (tok_out.ends_token),
        .ends_command (tok_out.ends_command),
        .error        (tok_out.error),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver. Ready changes only at the falling edge. When a hold-off is requested
    // the receiver keeps ready low for the HOLD_OFF_CYCLES hold-off, so the result
    // register and the input register both fill and cmd_in ready drops.
    initial
    begin
        tok_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                tok_out.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
            begin
                tok_out.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog. Any transaction on either channel restarts the count, so the limit
    // only has to cover the longest quiet stretch of a correct run.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_in.valid && cmd_in.ready) || (tok_out.valid && tok_out.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hex digit character for a nibble, with random letter case.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // Appends one byte to the command being built.
    function automatic void add_byte(input logic [7:0] b);
        cmd_bytes.insert(cmd_bytes.size(), b);
    endfunction

    // Offers one byte and returns at the falling edge after it was accepted. Valid is
    // left high on return; it is lowered when the next call decides to idle or a phase ends,
    // so valid never gets two assignments in one time step.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_in.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_in.valid   <= 1'b1;
        cmd_in.in_byte <= b;
        cmd_in.last    <= fin;
        @(posedge clk);
        while (!cmd_in.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Sends the whole command in cmd_bytes, marking its final byte.
    task automatic send_command();
        foreach (cmd_bytes[i])
            push_byte(cmd_bytes[i], i == cmd_bytes.size() - 1);
    endtask

    // Builds a random command. Most pieces are well formed (plain bytes, separators,
    // quotes, simple and hex escapes) so that the quote and escape logic is exercised
    // deeply; a minority are raw noise bytes and broken hex escapes. Some commands end
    // in the middle of an escape to provoke the end-of-command errors.
    task automatic build_random_command();
        int parts;
        int pick;
        cmd_bytes.delete();
        parts = $urandom_range(1, 10);
        repeat (parts)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                add_byte(8'($urandom_range(8'h21, 8'h7E)));
            end
            else if (pick < 50)
            begin
                case ($urandom_range(3))
                    0:       add_byte(CH_SPACE);
                    1:       add_byte(CH_TAB);
                    2:       add_byte(CH_LF);
                    default: add_byte(CH_CR);
                endcase
            end
            else if (pick < 60)
            begin
                add_byte(CH_QUOTE);
            end
            else if (pick < 72)
            begin
                add_byte(CH_BACKSLASH);
                case ($urandom_range(5))
                    0:       add_byte(CH_N);
                    1:       add_byte(CH_R);
                    2:       add_byte(CH_B);
                    3:       add_byte(CH_T);
                    4:       add_byte(CH_ZERO);
                    default: add_byte(8'($urandom_range(255)));
                endcase
            end
            else if (pick < 84)
            begin
                add_byte(CH_BACKSLASH);
                add_byte(CH_X);
                add_byte(hex_digit(4'($urandom_range(15))));
                add_byte(hex_digit(4'($urandom_range(15))));
            end
            else if (pick < 92)
            begin
                add_byte(8'($urandom_range(255)));
            end
            else
            begin
                // A hex escape whose first or second digit is not a hex digit.
                add_byte(CH_BACKSLASH);
                add_byte(CH_X);
                if ($urandom_range(1)) add_byte(hex_digit(4'($urandom_range(15))));
                add_byte(8'($urandom_range(1) ? $urandom_range(8'h67, 8'h7A)
                                              : $urandom_range(8'h80, 8'hFF)));
            end
        end
        case ($urandom_range(15))
            0:
            begin
                add_byte(CH_BACKSLASH);
            end
            1:
            begin
                add_byte(CH_BACKSLASH);
                add_byte(CH_X);
            end
            2:
            begin
                add_byte(CH_BACKSLASH);
                add_byte(CH_X);
                add_byte(hex_digit(4'($urandom_range(15))));
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        int  sent;
        bit  held;
        cmd_in.valid   = 1'b0;
        cmd_in.in_byte = 8'h00;
        cmd_in.last    = 1'b0;
        rst_n          = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed commands, sent with no idling on either side.
        // A NUL token ended by a space, a quoted token holding a tab, a CR ending it,
        // a hex escape with mixed case ended by LF, and 0xFF as the last byte so the
        // open token is closed by the end of the command.
        cmd_bytes = {8'h00, CH_SPACE, CH_QUOTE, CH_TAB, CH_QUOTE, CH_CR, CH_BACKSLASH,
                     CH_X, 8'h61, 8'h46, CH_LF, 8'hFF};
        send_command();
        // An unterminated quote as the whole command gives an empty token.
        cmd_bytes = {CH_QUOTE};
        send_command();
        // A newline escape, then a backslash on the final byte.
        cmd_bytes = {CH_BACKSLASH, CH_N, CH_BACKSLASH};
        send_command();
        // A hex escape cut short by the end of the command.
        cmd_bytes = {CH_BACKSLASH, CH_X, 8'h34};
        send_command();
        // A bad first hex digit, after which the rest of the command is skipped.
        cmd_bytes = {CH_BACKSLASH, CH_X, 8'h67, 8'h31, 8'h7A};
        send_command();

        // Random commands in four idling phases. Between phases the sender stops until
        // every expected result has arrived.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 78;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 78;
                end
                default:
                begin
                    src_idle_pct   = 37;
                    sink_stall_pct = 37;
                end
            endcase
            sent = 0;
            held = 1'b0;
            while (sent < PHASE_BYTES)
            begin
                // Midway through the busiest phase the receiver holds off for a long
                // stretch while the sender keeps offering bytes.
                if (phase == 0 && !held && sent >= PHASE_BYTES / 2)
                begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                build_random_command();
                send_command();
                sent += cmd_bytes.size();
            end
            cmd_in.valid <= 1'b0;
            @(negedge clk);
            while (pending != 0) @(negedge clk);
        end

        // Let the pipeline run on to show any stray result.
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== command_line_tokenizer_unit.f =====
+incdir+rtl
rtl/clt_pkg.sv
rtl/clt_if.sv
rtl/clt_in_stage.sv
rtl/clt_decoder.sv
rtl/clt_out_stage.sv
rtl/command_line_tokenizer_unit.sv
dv/tokenizer_checker.sv
dv/testbench.sv
